// ===== src/int_to_decimal_ascii_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the decimal ASCII formatter
// Concurrent checks that simulation builds turn on and synthesis builds drop.
// ---------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

`ifndef SYNTH
// Condition implies a consequence in the same cycle.
`define I2DA_ASSERT_SAME(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("i2da assertion failed");
// Condition implies a consequence in the next cycle.
`define I2DA_ASSERT_NEXT(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("i2da assertion failed");
`else
`define I2DA_ASSERT_SAME(label, cond, cons)
`define I2DA_ASSERT_NEXT(label, cond, cons)
`endif

`endif

// ===== src/i2da_pkg.sv =====
// ---------------------------------------------------------------------------
// i2da_pkg
// Shared constants and types of the decimal ASCII formatter.
// ---------------------------------------------------------------------------
package i2da_pkg;

   localparam int MAX_DIGITS = 10;
   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 6;
   localparam int DIGIT_W    = 4;
   localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
   // Only non-negative values are converted, so the sign bit is never shifted in.
   localparam int CONV_STEPS = VALUE_W - 1;
   localparam int STEP_W     = $clog2(CONV_STEPS);
   localparam int LEFT_W     = $clog2(MAX_DIGITS + 1);

   localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
   localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = DIGIT_W'(5);
   localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = DIGIT_W'(3);

   typedef struct packed {
      logic [BCD_W-1:0] bcd;       // kept decimal digits, most significant at the top
      logic             overflow;  // digits beyond the kept ones were dropped
   } i2da_bcd_type;

endpackage

// ===== src/i2da_dabble.sv =====
// ---------------------------------------------------------------------------
// i2da_dabble
// Bit-serial binary to BCD converter using the shift-and-add-3 method.
// ---------------------------------------------------------------------------
module i2da_dabble (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [i2da_pkg::VALUE_W-2:0] value,
   input  logic                         take,
   output logic                         busy,
   output logic                         result_valid,
   output i2da_pkg::i2da_bcd_type       result
);
   import i2da_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_HOLD
   } state_type;

   state_type              state_ff;
   logic [CONV_STEPS-1:0]  bin_ff;
   logic [BCD_W-1:0]       bcd_ff;
   logic                   ovf_ff;
   logic [STEP_W-1:0]      cnt_ff;
   logic [BCD_W-1:0]       adj_in;

   // Each digit of five or more gets three added so the following doubling
   // carries correctly into the next digit.
   always_comb begin
      logic [DIGIT_W-1:0] dig;
      adj_in = bcd_ff;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         dig = bcd_ff[i*DIGIT_W +: DIGIT_W];
         if (dig >= BCD_ADJ_MIN) begin
            adj_in[i*DIGIT_W +: DIGIT_W] = dig + BCD_ADJ_ADD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  bin_ff   <= value;
                  bcd_ff   <= '0;
                  ovf_ff   <= 1'b0;
                  cnt_ff   <= STEP_W'(CONV_STEPS - 1);
                  state_ff <= ST_SHIFT;
               end
            end
            ST_SHIFT: begin
               bcd_ff <= {adj_in[BCD_W-2:0], bin_ff[CONV_STEPS-1]};
               bin_ff <= {bin_ff[CONV_STEPS-2:0], 1'b0};
               ovf_ff <= ovf_ff | adj_in[BCD_W-1];
               cnt_ff <= cnt_ff - STEP_W'(1);
               if (cnt_ff == '0) begin
                  state_ff <= ST_HOLD;
               end
            end
            ST_HOLD: begin
               if (take) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign result_valid    = (state_ff == ST_HOLD);
   assign result.bcd      = bcd_ff;
   assign result.overflow = ovf_ff;

endmodule

// ===== src/i2da_emit.sv =====
// ---------------------------------------------------------------------------
// i2da_emit
// Digit serializer: shifts BCD digits out as ASCII characters, one per step.
// ---------------------------------------------------------------------------
module i2da_emit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  i2da_pkg::i2da_bcd_type      data,
   output logic                        idle,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [i2da_pkg::CHAR_W-1:0] rsp_char_code,
   output logic                        rsp_last_char
);
   import i2da_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type          state_ff;
   logic [BCD_W-1:0]   bcd_ff;
   logic               started_ff;
   logic [LEFT_W-1:0]  left_ff;
   logic               valid_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic               last_ff;

   logic [DIGIT_W-1:0] top_digit;
   logic               is_last;
   logic               emit;
   logic               out_free;

   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];
   assign is_last   = (left_ff == LEFT_W'(1));
   // Leading zeros are skipped unless digits were dropped; the final digit always goes.
   assign emit      = started_ff | (top_digit != '0) | is_last;
   assign out_free  = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (out_free) begin
                  valid_ff <= 1'b0;
               end
               if (load) begin
                  bcd_ff     <= data.bcd;
                  started_ff <= data.overflow;
                  left_ff    <= LEFT_W'(MAX_DIGITS);
                  state_ff   <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (out_free) begin
                  valid_ff <= emit;
                  if (emit) begin
                     char_ff    <= ASCII_ZERO + CHAR_W'(top_digit);
                     last_ff    <= is_last;
                     started_ff <= 1'b1;
                  end
                  bcd_ff  <= {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                  left_ff <= left_ff - LEFT_W'(1);
                  if (is_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign idle          = (state_ff == ST_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last_char = last_ff;

endmodule

// ===== src/int_to_decimal_ascii_top.sv =====
// ---------------------------------------------------------------------------
// int_to_decimal_ascii_top
// Formats signed 32-bit integers as decimal ASCII digit characters.
// ---------------------------------------------------------------------------
// Each request transaction carries one signed 32-bit value; the block answers
// with one response transaction per decimal digit, most significant first, as
// an ASCII code '0' to '9', with no leading zeros and the final digit marked
// by rsp_last_char. Zero yields the single character '0'. A negative value is
// accepted and produces no response at all. When more digits exist than the
// buffer of MAX_DIGITS holds, only the least significant MAX_DIGITS digits
// are sent, leading zeros among them included. A non-negative value is
// taken in and passed to the bit-serial converter, which shifts one binary
// bit per cycle into a BCD register; once done, it hands the digits to the
// serializer as soon as that is idle, which then walks all MAX_DIGITS digit
// positions at one per cycle (skipped leading zeros included) and
// slows down only when the response side stalls. The converter and the
// serializer work in parallel, so a new value is taken while the previous
// one is still being sent; without response stalls the converter sets the
// pace. A negative value is taken without starting a conversion.
// req_stall is high while the converter holds a value.

`include "int_to_decimal_ascii_top_defines.svh"

module int_to_decimal_ascii_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [i2da_pkg::VALUE_W-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [i2da_pkg::CHAR_W-1:0]  rsp_char_code,
   output logic                         rsp_last_char
);
   import i2da_pkg::*;

   logic         req_accept;
   logic         conv_start;
   logic         conv_busy;
   logic         conv_done;
   logic         emit_idle;
   logic         handoff;
   logic         rsp_is_digit;
   i2da_bcd_type conv_result;

   // A transaction is taken whenever the converter is free; negative values
   // are dropped right there and never start a conversion.
   assign req_stall  = conv_busy;
   assign req_accept = req_valid && !req_stall;
   assign conv_start = req_accept && !req_value[VALUE_W-1];

   // The converter keeps its digits until the serializer has finished the
   // previous number.
   assign handoff = conv_done && emit_idle;

   i2da_dabble u_dabble (
      .clock        (clock),
      .reset        (reset),
      .start        (conv_start),
      .value        (req_value[VALUE_W-2:0]),
      .take         (handoff),
      .busy         (conv_busy),
      .result_valid (conv_done),
      .result       (conv_result)
   );

   i2da_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load          (handoff),
      .data          (conv_result),
      .idle          (emit_idle),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

   // The outgoing code lies between '0' and '9'.
   assign rsp_is_digit = (rsp_char_code >= ASCII_ZERO) &&
                         (rsp_char_code <= ASCII_ZERO + CHAR_W'(9));

   // A started conversion must hold off the next request.
   `I2DA_ASSERT_NEXT(a_start_blocks_req, conv_start, req_stall)
   // Only decimal digit codes ever leave the block.
   `I2DA_ASSERT_SAME(a_char_is_digit, rsp_valid, rsp_is_digit)
   // Once a number has started, its digits follow without gaps.
   `I2DA_ASSERT_NEXT(a_no_gap_in_run, rsp_valid && !rsp_stall && !rsp_last_char, rsp_valid)
   // Digits are handed over only to an idle serializer, which then leaves idle.
   `I2DA_ASSERT_NEXT(a_handoff_busy, handoff, !emit_idle)

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the decimal ASCII formatter
// Sends signed 32-bit values, predicts the digit characters each one must
// produce and checks every response transaction against that prediction.
// ----------------------------------------------------------------------------

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import i2da_pkg::*;

   // One value waiting to be sent. When hold_for_drain is set, the sender
   // stops before this value until every predicted character has come back.
   typedef struct {
      logic signed [VALUE_W-1:0] value;
      bit                        hold_for_drain;
   } value_item_type;

   // One predicted character of a decimal run.
   typedef struct {
      logic [CHAR_W-1:0] char_code;
      logic              last_char;
   } digit_char_type;

   // Patterns of response back-pressure; each one lasts for a random stretch.
   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HALF,
      STALL_HEAVY
   } stall_mode_type;

   localparam int DIRECTED_COUNT = 22;
   localparam int RANDOM_COUNT   = 440;
   localparam int DRAIN_EVERY    = 110;
   localparam int SETTLE_CYCLES  = 80;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [VALUE_W-1:0]  req_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b1;
   logic [CHAR_W-1:0]          rsp_char_code;
   logic                       rsp_last_char;

   value_item_type pending_values[$];
   digit_char_type expected_chars[$];
   int             error_count = 0;
   // Set by the monitor after each edge when no character is outstanding;
   // the sender reads it at the following edge, so there is no ordering race.
   logic           all_chars_back = 1'b1;

   int             burst_left = 0;
   int             gap_left   = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_mode_left = 0;

   int_to_decimal_ascii_top i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

   // The clock runs with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Works out the characters that one accepted value must produce and
   // appends them to the expectation store. A negative value yields nothing,
   // zero yields a lone '0', and anything else yields its decimal digits,
   // most significant first, keeping at most MAX_DIGITS of the low ones.
   function automatic void queue_decimal_digits(input logic signed [VALUE_W-1:0] value);
      logic [DIGIT_W-1:0] digits [MAX_DIGITS];
      logic [VALUE_W-1:0] rest;
      int                 count;
      digit_char_type     ch;
      rest  = value;
      count = 0;
      if (value < 0) begin
         return;
      end
      if (rest == 0) begin
         ch.char_code = ASCII_ZERO;
         ch.last_char = 1'b1;
         expected_chars.push_back(ch);
         return;
      end
      while (rest != 0 && count < MAX_DIGITS) begin
         digits[count] = DIGIT_W'(rest % 10);
         rest          = rest / 10;
         count++;
      end
      while (count > 0) begin
         count--;
         ch.char_code = ASCII_ZERO + CHAR_W'(digits[count]);
         ch.last_char = (count == 0);
         expected_chars.push_back(ch);
      end
   endfunction

   // Draws one random value. Most values have a random number of digits, some
   // at the edges of that range, so that every run length appears often; the
   // rest are negatives, zero, tiny values and unrestricted 32-bit patterns.
   function automatic logic signed [VALUE_W-1:0] random_value();
      longint lo;
      longint hi;
      int     ndig;
      int     pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         return $urandom() | 32'h8000_0000;
      end else if (pick < 16) begin
         return $urandom_range(0, 9);
      end else if (pick < 24) begin
         return $urandom();
      end
      ndig = $urandom_range(1, 10);
      lo   = 1;
      for (int j = 1; j < ndig; j++) begin
         lo = lo * 10;
      end
      hi = lo * 10 - 1;
      if (hi > 64'h7FFF_FFFF) begin
         hi = 64'h7FFF_FFFF;
      end
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
         return 32'(lo);
      end else if (pick == 1) begin
         return 32'(hi);
      end
      return $urandom_range(32'(hi), 32'(lo));
   endfunction

   // Stimulus and end of run. The directed values come first: zero, single
   // digits, several power-of-ten boundaries that change the run length, the
   // largest positive value, and negatives including the most negative one.
   // Random values follow, with a pause for a full drain every so often.
   initial begin
      logic signed [VALUE_W-1:0] directed [DIRECTED_COUNT];
      value_item_type            item;
      directed = '{
         32'sd0, 32'sd1, 32'sd9, 32'sd10, 32'sd99, 32'sd100, 32'sd0, 32'sd5,
         32'sd12345, 32'sd999999999, 32'sd1000000000, 32'sd1234567890,
         32'sd1073741824, 32'sd1999999999, 32'sd2147483646, 32'sd2147483647,
         -32'sd1, -32'sd123, -32'sd2147483648, 32'sd7, 32'sd100000, 32'sd99999
      };
      foreach (directed[i]) begin
         item.value          = directed[i];
         item.hold_for_drain = 1'b0;
         pending_values.push_back(item);
      end
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         item.value          = random_value();
         // Every so often the sender waits until the block has fully drained.
         item.hold_for_drain = (i % DRAIN_EVERY == 0);
         pending_values.push_back(item);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The end of the run is checked on the falling edge, when all updates of the
      // rising edge have settled.
      @(negedge clock);
      while (pending_values.size() != 0 || req_valid) begin
         @(negedge clock);
      end
      while (expected_chars.size() != 0) begin
         @(negedge clock);
      end
      // Let the block run on a while to catch any stray character.
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("[int_to_decimal_ascii_top] OK");
      end else begin
         $display("[int_to_decimal_ascii_top] ERROR");
      end
      $finish;
   end

   // Run limit, several times the slowest correct run.
   initial begin
      #1_000_000;
      $display("[int_to_decimal_ascii_top] ERROR");
      $finish;
   end

   // Request driver. It sends in bursts of random length separated by random
   // gaps, some of them zero, so that back-to-back stretches also occur. A
   // payload only changes once the current transaction has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_value <= '0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_values.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_values[0].hold_for_drain && (req_valid || !all_chars_back)) begin
            // Drop valid first so that the drain flag covers the last value sent.
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_value <= pending_values[0].value;
            pending_values.pop_front();
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // Response back-pressure. The pattern switches at random between no
   // stalls, rare stalls, even stalls and stalls most of the time.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode      = stall_mode_type'($urandom_range(0, 3));
            stall_mode_left = $urandom_range(20, 200);
         end else begin
            stall_mode_left--;
         end
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_LIGHT: begin
               rsp_stall <= ($urandom_range(0, 7) == 0);
            end
            STALL_HALF: begin
               rsp_stall <= ($urandom_range(0, 1) == 1);
            end
            default: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
         endcase
      end
   end

   // Monitor. A response transaction is checked against the oldest predicted
   // character; a request transaction adds its predicted characters. The
   // check runs first, though a value's characters can never come back in the
   // cycle that the value is taken.
   always @(posedge clock) begin
      digit_char_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected character, expected none, got char_code %0d last_char %0b",
                        $time, rsp_char_code, rsp_last_char);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_char_code !== want.char_code) begin
                  $display("%0t: char_code mismatch, expected %0d, got %0d",
                           $time, want.char_code, rsp_char_code);
                  error_count++;
               end
               if (rsp_last_char !== want.last_char) begin
                  $display("%0t: last_char mismatch, expected %0b, got %0b",
                           $time, want.last_char, rsp_last_char);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            queue_decimal_digits(req_value);
         end
      end
      all_chars_back <= (expected_chars.size() == 0);
   end

endmodule
